/* rtl/kfc_pkg.sv */
`timescale 1ns / 1ps

package kfc_pkg;

  // fifo geometry
  localparam int FIFO_DEPTH = 1024;

  // field widths
  localparam int ACTION_W    = 2;
  localparam int KEY_W       = 16;
  localparam int ADDR_W      = 8;
  localparam int DATA_W      = 32;
  localparam int ENTRY_W     = KEY_W + 1;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_STATUS_ADDR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_ADDR   = 1'd1;

  localparam logic [ADDR_W-1:0] STATUS_ADDR_RST = 8'd0;
  localparam logic [ADDR_W-1:0] DATA_ADDR_RST   = 8'd4;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_KEY_DOWN  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_KEY_UP    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_BUS_READ  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_BUS_WRITE = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic exec;      // input transaction taken this cycle
    logic fin_read;  // store read data is valid this cycle
  } kfc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pop_hit;    // current item pops a stored entry
    logic skid_full;  // no room for another result
    logic empty;
    logic irq;
  } kfc_sts_t;

endpackage

/* rtl/kfc_ram.sv */
`timescale 1ns / 1ps

module kfc_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/kfc_ctrl.sv */
`timescale 1ns / 1ps

module kfc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  kfc_pkg::kfc_sts_t sts,
  output kfc_pkg::kfc_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic state_r;
  logic state_nxt;

  assign in_tready    = (state_r == ST_IDLE) && !sts.skid_full;
  assign cmd.exec     = in_tvalid && in_tready;
  assign cmd.fin_read = (state_r == ST_READ);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.exec && sts.pop_hit) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/kfc_dp.sv */
`timescale 1ns / 1ps

module kfc_dp #(
  parameter int FIFO_DEPTH = kfc_pkg::FIFO_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [kfc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kfc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [kfc_pkg::ACTION_W-1:0]     in_action,
  input  logic [kfc_pkg::KEY_W-1:0]        in_key_code,
  input  logic [kfc_pkg::ADDR_W-1:0]       in_address,
  input  kfc_pkg::kfc_cmd_t                cmd,
  output kfc_pkg::kfc_sts_t                sts,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [kfc_pkg::DATA_W-1:0]       out_read_data,
  output logic                             out_irq_level
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  logic [PTR_W-1:0] wp_r, wp_nxt, wp_inc;
  logic [PTR_W-1:0] rp_r, rp_nxt, rp_inc;
  logic             irq_r, irq_nxt;
  logic [kfc_pkg::ADDR_W-1:0] status_addr_r, data_addr_r;

  logic is_key, is_rd, stat_hit, data_hit, full, empty;
  logic ram_wr, ram_rd;
  logic [kfc_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic                       res_vld;
  logic [kfc_pkg::DATA_W-1:0] res_data;
  logic                       res_irq;

  logic                       out_vld_r, out_vld_nxt;
  logic [kfc_pkg::DATA_W-1:0] out_data_r, out_data_nxt;
  logic                       out_irq_r, out_irq_nxt;
  logic                       skid_vld_r, skid_vld_nxt;
  logic [kfc_pkg::DATA_W-1:0] skid_data_r, skid_data_nxt;
  logic                       skid_irq_r, skid_irq_nxt;
  logic                       pop_out;

  // circular pointers, wrap at any depth
  assign wp_inc = (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
  assign rp_inc = (rp_r == PTR_LAST) ? '0 : rp_r + 1'b1;
  assign empty  = (wp_r == rp_r);
  assign full   = (wp_inc == rp_r);

  // decode; status address wins when both match
  assign is_key   = (in_action == kfc_pkg::ACT_KEY_DOWN) || (in_action == kfc_pkg::ACT_KEY_UP);
  assign is_rd    = (in_action == kfc_pkg::ACT_BUS_READ);
  assign stat_hit = is_rd && (in_address == status_addr_r);
  assign data_hit = is_rd && !stat_hit && (in_address == data_addr_r);

  assign sts.pop_hit   = data_hit && !empty;
  assign sts.skid_full = skid_vld_r;
  assign sts.empty     = empty;
  assign sts.irq       = irq_r;

  assign ram_wr    = cmd.exec && is_key && !full;
  assign ram_wdata = {(in_action == kfc_pkg::ACT_KEY_UP), in_key_code};
  assign ram_rd    = cmd.exec && sts.pop_hit;

  kfc_ram #(
    .WIDTH (kfc_pkg::ENTRY_W),
    .DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (wp_r),
    .wr_data (ram_wdata),
    .rd_en   (ram_rd),
    .rd_addr (rp_r),
    .rd_data (ram_rdata)
  );

  // pointer and interrupt update at acceptance
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    irq_nxt = irq_r;
    if (cmd.exec) begin
      if (is_key) begin
        if (!full) begin
          wp_nxt = wp_inc;
        end
        irq_nxt = 1'b1;
      end else if (data_hit) begin
        if (empty) begin
          irq_nxt = 1'b0;
        end else begin
          rp_nxt = rp_inc;
          if (rp_inc == wp_r) begin
            irq_nxt = 1'b0;
          end
        end
      end
    end
  end

  // result: immediate, or from the store in the cycle after acceptance
  always_comb begin
    res_vld  = 1'b0;
    res_data = '0;
    res_irq  = irq_nxt;
    if (cmd.fin_read) begin
      res_vld  = 1'b1;
      res_data = {ram_rdata[kfc_pkg::KEY_W], {(kfc_pkg::DATA_W - kfc_pkg::KEY_W - 1){1'b0}},
                  ram_rdata[kfc_pkg::KEY_W-1:0]};
      res_irq  = irq_r;
    end else if (cmd.exec && !sts.pop_hit) begin
      res_vld = 1'b1;
      if (stat_hit) begin
        res_data = {{(kfc_pkg::DATA_W - 1){1'b0}}, !empty};
      end
    end
  end

  // output register with one skid slot
  assign pop_out = out_vld_r && out_ready;

  always_comb begin
    out_vld_nxt   = out_vld_r;
    out_data_nxt  = out_data_r;
    out_irq_nxt   = out_irq_r;
    skid_vld_nxt  = skid_vld_r;
    skid_data_nxt = skid_data_r;
    skid_irq_nxt  = skid_irq_r;
    if (pop_out) begin
      out_vld_nxt = 1'b0;
    end
    if (skid_vld_r && pop_out) begin
      out_vld_nxt  = 1'b1;
      out_data_nxt = skid_data_r;
      out_irq_nxt  = skid_irq_r;
      skid_vld_nxt = 1'b0;
    end else if (res_vld) begin
      if (!out_vld_r || pop_out) begin
        out_vld_nxt  = 1'b1;
        out_data_nxt = res_data;
        out_irq_nxt  = res_irq;
      end else begin
        skid_vld_nxt  = 1'b1;
        skid_data_nxt = res_data;
        skid_irq_nxt  = res_irq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r          <= '0;
      rp_r          <= '0;
      irq_r         <= 1'b0;
      out_vld_r     <= 1'b0;
      skid_vld_r    <= 1'b0;
      status_addr_r <= kfc_pkg::STATUS_ADDR_RST;
      data_addr_r   <= kfc_pkg::DATA_ADDR_RST;
    end else begin
      wp_r       <= wp_nxt;
      rp_r       <= rp_nxt;
      irq_r      <= irq_nxt;
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
      if (cfg_wr_en && (cfg_index == kfc_pkg::CFG_STATUS_ADDR)) begin
        status_addr_r <= cfg_wdata;
      end
      if (cfg_wr_en && (cfg_index == kfc_pkg::CFG_DATA_ADDR)) begin
        data_addr_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    out_irq_r   <= out_irq_nxt;
    skid_data_r <= skid_data_nxt;
    skid_irq_r  <= skid_irq_nxt;
  end

  assign out_valid     = out_vld_r;
  assign out_read_data = out_data_r;
  assign out_irq_level = out_irq_r;

endmodule

/* rtl/keyboard_fifo_controller_core.sv */
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// in_       slave      in_tvalid/in_tready    key event or bus access
// out_      master     out_tvalid/out_tready  read data and interrupt level
// cfg_      write      cfg_wr_en              status and data register offsets
//
// key events, status reads, writes and unmatched reads form their result in the cycle they are accepted
// a data read of a non-empty fifo completes in the cycle after acceptance: the key store has a registered read port
// a full output register plus its skid slot holds off in_tready until out_tready drains it
// rst_n is synchronous: pointers, interrupt, output valids and offsets reset; the store does not
// stalling out_ never drops a transaction: at most two results wait on the output side

module keyboard_fifo_controller_core #(
  parameter int FIFO_DEPTH = kfc_pkg::FIFO_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration writes
  input  logic                                 cfg_wr_en,
  input  logic [kfc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [kfc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [kfc_pkg::IN_TDATA_W-1:0]       in_tdata,   // action[1:0], key_code[17:2], address[25:18]
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [kfc_pkg::OUT_TDATA_W-1:0]      out_tdata   // read_data[31:0], irq_level[32]
);

  localparam int KEY_LO  = kfc_pkg::ACTION_W;
  localparam int ADDR_LO = KEY_LO + kfc_pkg::KEY_W;
  localparam int IN_USED = ADDR_LO + kfc_pkg::ADDR_W;

  kfc_pkg::kfc_cmd_t cmd;
  kfc_pkg::kfc_sts_t sts;

  logic [kfc_pkg::ACTION_W-1:0] in_action;
  logic [kfc_pkg::KEY_W-1:0]    in_key_code;
  logic [kfc_pkg::ADDR_W-1:0]   in_address;
  logic [kfc_pkg::DATA_W-1:0]   out_read_data;
  logic                         out_irq_level;

  // unpack the input transaction, padding bits are ignored
  assign in_action   = in_tdata[KEY_LO-1:0];
  assign in_key_code = in_tdata[ADDR_LO-1:KEY_LO];
  assign in_address  = in_tdata[IN_USED-1:ADDR_LO];

  kfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  kfc_dp #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_action     (in_action),
    .in_key_code   (in_key_code),
    .in_address    (in_address),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_read_data (out_read_data),
    .out_irq_level (out_irq_level)
  );

  // pack the result, zero fill to whole bytes
  assign out_tdata = {{(kfc_pkg::OUT_TDATA_W - kfc_pkg::DATA_W - 1){1'b0}},
                      out_irq_level, out_read_data};

  // interrupt level tracks fifo occupancy
  a_irq_follows_fill: assert property (@(posedge clk) disable iff (!rst_n)
    sts.irq == !sts.empty)
    else $error("interrupt level disagrees with fifo occupancy");

  // a popping read always completes from the store in the following cycle
  a_pop_completes: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && sts.pop_hit) |=> cmd.fin_read)
    else $error("store read did not complete after pop");

  // nothing is taken while a store read is in flight
  a_no_accept_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin_read |-> !in_tready)
    else $error("input accepted during store read");

endmodule
